>>> rtl/msfm_pkg.sv
// ----------------------------------------------------------------------------
// msfm_pkg
// Shared types and constants of the masked SAD frame matcher.
// ----------------------------------------------------------------------------
package msfm_pkg;

  localparam int PIXEL_COUNT_BITS = 24;
  localparam int CHAN_W           = 8;
  localparam int SUM_W            = 32;
  localparam int FRAC_W           = 4;
  localparam int SCORE_W          = 12;
  localparam int DIVIDEND_W       = SUM_W + FRAC_W;
  localparam int STEP_W           = $clog2(DIVIDEND_W);
  localparam int CHAN_SUM_W       = CHAN_W + 2;

  // floor(t / 3) for t <= 765 as (t * 683) >> 11
  localparam int DIV3_MUL         = 683;
  localparam int DIV3_SHIFT       = 11;
  localparam int DIV3_PROD_W      = CHAN_SUM_W + 10;

  localparam logic [SCORE_W-1:0] SCORE_MAX       = '1;
  localparam logic [SCORE_W-1:0] THRESHOLD_RESET = SCORE_W'(96);

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  typedef enum logic {
    REG_COLOR_MODE = 1'b0,
    REG_THRESHOLD  = 1'b1
  } reg_index_t;

  typedef enum logic {
    MODE_RGB  = 1'b0,
    MODE_LUMA = 1'b1
  } color_mode_t;

  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_DIVIDE,
    ST_HOLD
  } state_t;

endpackage

>>> rtl/msfm_pixel_if.sv
// ----------------------------------------------------------------------------
// msfm_pixel_if
// Pixel channel: mask and frame channels plus end-of-frame mark.
// ----------------------------------------------------------------------------
interface msfm_pixel_if import msfm_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] mask_c0;
  logic [CHAN_W-1:0] mask_c1;
  logic [CHAN_W-1:0] mask_c2;
  logic [CHAN_W-1:0] frame_c0;
  logic [CHAN_W-1:0] frame_c1;
  logic [CHAN_W-1:0] frame_c2;
  logic              last_pixel;

  modport source (
    output valid, mask_c0, mask_c1, mask_c2, frame_c0, frame_c1, frame_c2, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, mask_c0, mask_c1, mask_c2, frame_c0, frame_c1, frame_c2, last_pixel,
    output ready
  );
endinterface

>>> rtl/msfm_result_if.sv
// ----------------------------------------------------------------------------
// msfm_result_if
// Result channel: per-frame score and flags.
// ----------------------------------------------------------------------------
interface msfm_result_if import msfm_pkg::*;;
  logic               valid;
  logic               ready;
  logic [SCORE_W-1:0] score_q4;
  logic               is_match;
  logic               no_pixels;

  modport source (output valid, score_q4, is_match, no_pixels, input ready);
  modport sink   (input  valid, score_q4, is_match, no_pixels, output ready);
endinterface

>>> rtl/msfm_divider.sv
// ----------------------------------------------------------------------------
// msfm_divider
// Restoring divider, one quotient bit per cycle, quotient saturated to score.
// ----------------------------------------------------------------------------
module msfm_divider import msfm_pkg::*; #(
  parameter int CountW = PIXEL_COUNT_BITS + 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [CountW-1:0]     divisor,
  output logic                  done,
  output logic [SCORE_W-1:0]    quotient
);

  logic                  busy;
  logic [STEP_W-1:0]     step;
  logic [DIVIDEND_W-1:0] dvd;
  logic [CountW-1:0]     dsr;
  logic [CountW-1:0]     rem;
  logic [SCORE_W-1:0]    quo;
  logic                  sat;

  logic [CountW:0]       trial;
  logic                  fits;
  logic [CountW:0]       diff;

  // shift in the next dividend bit and try the subtract
  always_comb begin
    trial = {rem, dvd[DIVIDEND_W-1]};
    diff  = trial - {1'b0, dsr};
    fits  = trial >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      // flag the cycle after the last step
      done <= ~start & busy & (step == STEP_W'(DIVIDEND_W - 1));
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(DIVIDEND_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
      quo <= '0;
      sat <= 1'b0;
    end else if (busy) begin
      dvd <= {dvd[DIVIDEND_W-2:0], 1'b0};
      rem <= fits ? diff[CountW-1:0] : trial[CountW-1:0];
      quo <= {quo[SCORE_W-2:0], fits};
      // any bit pushed past the top of the score saturates it
      sat <= sat | quo[SCORE_W-1];
    end
  end

  assign quotient = sat ? SCORE_MAX : quo;

endmodule

>>> rtl/masked_sad_frame_matcher_core.sv
// ----------------------------------------------------------------------------
// masked_sad_frame_matcher_core
// Masked mean absolute difference between a mask image and a video frame.
// ----------------------------------------------------------------------------
// Usage:
//   pix  - one word per pixel: three mask channels, three frame channels and
//          last_pixel. Pixels are taken one per cycle while accumulating.
//   res  - one word per frame: score_q4 = floor(16 * sum / count) saturated
//          at 4095, is_match = score_q4 < match_threshold, no_pixels when
//          no pixel of the frame counted (then score 4095, no match).
//   APB  - register 0 at 0x0 (color_mode), register 1 at 0x4
//          (match_threshold); pready is always high, reads return values.
// Throughput: one pixel per cycle inside a frame. The pixel that carries
//   last_pixel starts the restoring divider, which handles one dividend
//   bit per step; pix.ready then stays low until the result word is loaded
//   into the output register, so no pixel is taken while the divider runs.
// Result path: after the last pixel word is accepted the divider works
//   through the 36 dividend bits and flags done, then the output register is loaded.
// Stall: the result sits in an output register; while it waits the next
//   frame's pixels are still taken. A second result waits in the divider,
//   with pix.ready low, until the first one is taken.
// Reset: rst clears accumulators and control; color_mode returns to RGB and
//   match_threshold to 96 (6.0 in Q4).
// ----------------------------------------------------------------------------
module masked_sad_frame_matcher_core import msfm_pkg::*; #(
  parameter int PixelCountBits = PIXEL_COUNT_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  msfm_pixel_if.sink            pix,
  msfm_result_if.source         res,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int CountW = PixelCountBits + 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  color_mode_t        color_mode;
  logic [SCORE_W-1:0] match_threshold;
  reg_index_t         reg_sel;
  logic               reg_write;

  assign reg_sel   = reg_index_t'(paddr[2]);
  assign reg_write = psel & penable & pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode      <= MODE_RGB;
      match_threshold <= THRESHOLD_RESET;
    end else if (reg_write) begin
      unique case (reg_sel)
        REG_COLOR_MODE: color_mode      <= color_mode_t'(pwdata[0]);
        REG_THRESHOLD:  match_threshold <= pwdata[SCORE_W-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_COLOR_MODE: prdata = {{(APB_DATA_W-1){1'b0}}, color_mode};
      REG_THRESHOLD:  prdata = {{(APB_DATA_W-SCORE_W){1'b0}}, match_threshold};
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Per-pixel difference
  // ---------------------------------------------------------------------------
  logic [CHAN_W-1:0]      ad0;
  logic [CHAN_W-1:0]      ad1;
  logic [CHAN_W-1:0]      ad2;
  logic [CHAN_SUM_W-1:0]  chan_sum;
  logic [DIV3_PROD_W-1:0] div3_prod;
  logic [CHAN_W-1:0]      pix_diff;
  logic                   pix_counts;

  always_comb begin
    ad0 = (pix.mask_c0 >= pix.frame_c0) ? pix.mask_c0 - pix.frame_c0
                                        : pix.frame_c0 - pix.mask_c0;
    ad1 = (pix.mask_c1 >= pix.frame_c1) ? pix.mask_c1 - pix.frame_c1
                                        : pix.frame_c1 - pix.mask_c1;
    ad2 = (pix.mask_c2 >= pix.frame_c2) ? pix.mask_c2 - pix.frame_c2
                                        : pix.frame_c2 - pix.mask_c2;
    chan_sum  = CHAN_SUM_W'(ad0) + CHAN_SUM_W'(ad1) + CHAN_SUM_W'(ad2);
    // truncated mean of three channels by reciprocal multiply
    div3_prod = DIV3_PROD_W'(chan_sum) * DIV3_PROD_W'(DIV3_MUL);
    if (color_mode == MODE_LUMA) begin
      pix_counts = (pix.mask_c0 != '0);
      pix_diff   = ad0;
    end else begin
      pix_counts = (pix.mask_c0 != '0) || (pix.mask_c1 != '0) || (pix.mask_c2 != '0);
      pix_diff   = div3_prod[DIV3_SHIFT +: CHAN_W];
    end
  end

  // ---------------------------------------------------------------------------
  // Accumulators, saturating
  // ---------------------------------------------------------------------------
  logic [SUM_W-1:0]  diff_sum;
  logic [SUM_W-1:0]  diff_sum_next;
  logic [CountW-1:0] counted_pixels;
  logic [CountW-1:0] counted_pixels_next;
  logic [SUM_W:0]    sum_wide;
  logic              pix_accept;

  assign pix_accept = pix.valid & pix.ready;

  always_comb begin
    sum_wide            = {1'b0, diff_sum} + (SUM_W+1)'(pix_diff);
    diff_sum_next       = diff_sum;
    counted_pixels_next = counted_pixels;
    if (pix_counts) begin
      diff_sum_next = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
      if (counted_pixels != '1) begin
        counted_pixels_next = counted_pixels + CountW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_sum       <= '0;
      counted_pixels <= '0;
    end else if (pix_accept) begin
      // clear for the next frame once the last pixel is in
      diff_sum       <= pix.last_pixel ? '0 : diff_sum_next;
      counted_pixels <= pix.last_pixel ? '0 : counted_pixels_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Final division: floor(16 * sum / count) on the divider
  // ---------------------------------------------------------------------------
  logic               div_start;
  logic               div_done;
  logic [SCORE_W-1:0] div_quotient;
  logic               none_seen;

  assign div_start = pix_accept & pix.last_pixel;

  msfm_divider #(
    .CountW (CountW)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({diff_sum_next, {FRAC_W{1'b0}}}),
    .divisor  (counted_pixels_next),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // remember an empty frame; the divider runs anyway but its quotient is unused
  always_ff @(posedge clk) begin
    if (div_start) begin
      none_seen <= (counted_pixels_next == '0);
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  state_t state;
  state_t state_next;
  logic   out_load;
  logic   out_valid;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_ACCUM:  if (div_start) state_next = ST_DIVIDE;
      ST_DIVIDE: if (div_done)  state_next = ST_HOLD;
      ST_HOLD:   if (out_load)  state_next = ST_ACCUM;
      default:   state_next = ST_ACCUM;
    endcase
  end

  always_comb begin
    pix.ready = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      ST_ACCUM:  pix.ready = 1'b1;
      ST_DIVIDE: ;
      ST_HOLD:   out_load  = ~out_valid | res.ready;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACCUM;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: hold the word until the receiver takes it
  // ---------------------------------------------------------------------------
  logic [SCORE_W-1:0] score_reg;
  logic               match_reg;
  logic               none_reg;
  logic [SCORE_W-1:0] score_calc;

  assign score_calc = none_seen ? SCORE_MAX : div_quotient;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      score_reg <= score_calc;
      match_reg <= ~none_seen & (score_calc < match_threshold);
      none_reg  <= none_seen;
    end
  end

  assign res.valid     = out_valid;
  assign res.score_q4  = score_reg;
  assign res.is_match  = match_reg;
  assign res.no_pixels = none_reg;

endmodule
